@@ src/range_event_duration_aggregator_core_assert.svh @@
// Assertion macros for the range event duration aggregator
`ifndef RANGE_EVENT_DURATION_AGGREGATOR_CORE_ASSERT_SVH
`define RANGE_EVENT_DURATION_AGGREGATOR_CORE_ASSERT_SVH
`define REDA_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define REDA_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`endif

@@ src/reda_pkg.sv @@
// Package for the range event duration aggregator
package reda_pkg;
  localparam int unsigned DefTableEntries = 64;
  localparam int unsigned DefTimeBits = 48;
  localparam int unsigned TotalW = 56;
  localparam int unsigned CntW = 32;
  localparam int unsigned WinW = 49;
  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic CFG_RANGE_START = 1'b0;
  localparam logic CFG_RANGE_END = 1'b1;
endpackage

@@ src/range_event_duration_aggregator_core.sv @@
// Top level: windowed per-name event duration aggregation table with sorted readout
// An item is taken when start is high and busy low. An add walks the name table in memory,
// one entry per cycle, then does one read-modify-write. A readout does a selection pass over
// the table per result, each result shown for one cycle on out_strobe with out_last on the
// final one; the receiver cannot stall. A clear completes at its transfer edge. Configuration
// is written only while idle.
module range_event_duration_aggregator_core
  import reda_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DefTableEntries,
  parameter int unsigned TIME_BITS = DefTimeBits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_req_type,
  input  logic [47:0]          in_event_start,
  input  logic [47:0]          in_event_duration,
  input  logic [31:0]          in_event_name,
  input  logic [31:0]          in_event_index,
  input  logic                 in_is_end_marker,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data,
  output logic                 out_strobe,
  output logic                 out_entry_valid,
  output logic [31:0]          out_summary_name,
  output logic [31:0]          out_hit_count,
  output logic [55:0]          out_total_time,
  output logic [47:0]          out_shortest_time,
  output logic [47:0]          out_longest_time,
  output logic [31:0]          out_longest_event,
  output logic [31:0]          out_events_counted,
  output logic signed [48:0]   out_window_length,
  output logic                 out_names_dropped,
  output logic                 out_last
);
  `include "range_event_duration_aggregator_core_assert.svh"

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned NW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [TotalW-1:0] TotMax = '1;

  typedef struct packed {
    logic [31:0]          key;
    logic [CntW-1:0]      cnt;
    logic [TotalW-1:0]    tot;
    logic [TIME_BITS-1:0] mn;
    logic [TIME_BITS-1:0] mx;
    logic [31:0]          bidx;
    logic [TIME_BITS-1:0] bdur;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLIP, S_SRCH, S_UPD, S_RSCAN, S_RWAIT, S_RFETCH, S_REMIT
  } state_t;

  ent_t mem [TABLE_ENTRIES];
  ent_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wr_d;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_d;
    rd_q <= mem[rd_addr];
  end

  state_t state_r;
  logic [TIME_BITS-1:0] rs_r, re_r, st_r, dur_r, clip_r;
  logic [31:0] name_r, idx_r;
  logic [NW-1:0] used_r, ptr_r, emit_r;
  logic [NW-1:0] rptr_r;
  logic [CntW-1:0] contrib_r;
  logic ovf_r, rvalid_r, hit_r;
  logic [AW-1:0] hit_a_r;
  logic [TotalW-1:0] prev_tot_r, best_tot_r;
  logic [NW-1:0] prev_i_r, best_i_r;
  logic best_ok_r, first_r;

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  // clip arithmetic
  logic [TIME_BITS:0] hi_w, lo_w;
  always_comb begin
    lo_w = (st_r > rs_r) ? {1'b0, st_r} : {1'b0, rs_r};
    hi_w = {1'b0, st_r} + {1'b0, dur_r};
    if (hi_w > {1'b0, re_r}) hi_w = {1'b0, re_r};
  end

  // update datapath
  logic [TotalW:0] sum_w;
  always_comb begin
    sum_w = {1'b0, rd_q.tot} + {{(TotalW + 1 - TIME_BITS){1'b0}}, clip_r};
    wr_d = rd_q;
    wr_d.cnt = (rd_q.cnt < CntMax) ? rd_q.cnt + 1'b1 : rd_q.cnt;
    wr_d.tot = sum_w[TotalW] ? TotMax : sum_w[TotalW-1:0];
    if (clip_r < rd_q.mn) wr_d.mn = clip_r;
    if (clip_r > rd_q.mx) wr_d.mx = clip_r;
    if (dur_r > rd_q.bdur) begin
      wr_d.bdur = dur_r;
      wr_d.bidx = idx_r;
    end
    if (!hit_r) begin
      wr_d.key = name_r;
      wr_d.cnt = CntW'(1);
      wr_d.tot = {{(TotalW - TIME_BITS){1'b0}}, clip_r};
      wr_d.mn = clip_r;
      wr_d.mx = clip_r;
      wr_d.bidx = idx_r;
      wr_d.bdur = dur_r;
    end
    wr_en = (state_r == S_UPD) && (hit_r || used_r < NW'(TABLE_ENTRIES));
    wr_addr = hit_r ? hit_a_r : used_r[AW-1:0];
  end

  // readout candidate: strictly after previous in (total desc, index asc)
  logic rd_vld_cmp, after_prev, better;
  logic [NW-1:0] cand_i;
  always_comb begin
    cand_i = rptr_r - 1'b1;
    after_prev = first_r || (rd_q.tot < prev_tot_r) ||
                 (rd_q.tot == prev_tot_r && cand_i > prev_i_r);
    better = !best_ok_r || (rd_q.tot > best_tot_r);
    rd_vld_cmp = rvalid_r && after_prev && better;
    rd_addr = (state_r == S_SRCH || state_r == S_RSCAN || state_r == S_RWAIT) ?
              ptr_r[AW-1:0] : best_i_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rs_r <= '0;
      re_r <= '0;
      used_r <= '0;
      contrib_r <= '0;
      ovf_r <= 1'b0;
      out_strobe <= 1'b0;
      rvalid_r <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      rvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_RANGE_START) rs_r <= cfg_data[TIME_BITS-1:0];
            else re_r <= cfg_data[TIME_BITS-1:0];
          end
          if (start) begin
            st_r <= in_event_start[TIME_BITS-1:0];
            dur_r <= in_event_duration[TIME_BITS-1:0];
            name_r <= in_event_name;
            idx_r <= in_event_index;
            ptr_r <= '0;
            hit_r <= 1'b0;
            first_r <= 1'b1;
            emit_r <= '0;
            best_ok_r <= 1'b0;
            rptr_r <= '0;
            case (in_req_type)
              REQ_ADD: begin
                if (!in_is_end_marker && in_event_duration[TIME_BITS-1:0] != '0)
                  state_r <= S_CLIP;
              end
              REQ_READ: state_r <= S_RSCAN;
              REQ_CLEAR: begin
                used_r <= '0;
                contrib_r <= '0;
                ovf_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_CLIP: begin
          if (hi_w <= lo_w) state_r <= S_IDLE;
          else begin
            clip_r <= hi_w[TIME_BITS-1:0] - lo_w[TIME_BITS-1:0];
            if (contrib_r < CntMax) contrib_r <= contrib_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (rvalid_r && rd_q.key == name_r) begin
            hit_r <= 1'b1;
            hit_a_r <= cand_i[AW-1:0];
            rptr_r <= '0;
            state_r <= S_RWAIT;
            ptr_r <= cand_i;
          end else if (ptr_r < used_r) begin
            ptr_r <= ptr_r + 1'b1;
            rptr_r <= ptr_r + 1'b1;
            rvalid_r <= 1'b1;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_RWAIT: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (!hit_r) begin
            if (used_r < NW'(TABLE_ENTRIES)) used_r <= used_r + 1'b1;
            else ovf_r <= 1'b1;
          end
          state_r <= S_IDLE;
        end
        S_RSCAN: begin
          if (rd_vld_cmp) begin
            best_ok_r <= 1'b1;
            best_tot_r <= rd_q.tot;
            best_i_r <= cand_i;
          end
          if (ptr_r < used_r) begin
            ptr_r <= ptr_r + 1'b1;
            rptr_r <= ptr_r + 1'b1;
            rvalid_r <= 1'b1;
          end else if (!rvalid_r) begin
            state_r <= S_RFETCH;
          end
        end
        S_RFETCH: state_r <= S_REMIT;
        S_REMIT: begin
          out_strobe <= 1'b1;
          out_entry_valid <= (used_r != '0);
          out_summary_name <= (used_r != '0) ? rd_q.key : '0;
          out_hit_count <= (used_r != '0) ? rd_q.cnt : '0;
          out_total_time <= (used_r != '0) ? rd_q.tot : '0;
          out_shortest_time <= (used_r != '0) ? 48'(rd_q.mn) : '0;
          out_longest_time <= (used_r != '0) ? 48'(rd_q.mx) : '0;
          out_longest_event <= (used_r != '0) ? rd_q.bidx : '0;
          out_events_counted <= contrib_r;
          out_window_length <= WinW'({1'b0, re_r} - {1'b0, rs_r});
          out_names_dropped <= ovf_r;
          out_last <= (used_r == '0) || (emit_r + 1'b1 == used_r);
          emit_r <= emit_r + 1'b1;
          prev_tot_r <= rd_q.tot;
          prev_i_r <= best_i_r;
          first_r <= 1'b0;
          best_ok_r <= 1'b0;
          ptr_r <= '0;
          if ((used_r == '0) || (emit_r + 1'b1 == used_r)) state_r <= S_IDLE;
          else state_r <= S_RSCAN;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `REDA_ASSERT_IMP(a_out_idle, clk, rst_n, out_strobe && out_last, state_r == S_IDLE)
  `REDA_ASSERT_IMP(a_used_max, clk, rst_n, 1'b1, used_r <= NW'(TABLE_ENTRIES))
  `REDA_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, !busy)
endmodule
